// ===== hw/rtl/stereo_plucked_string_synth_defines.svh =====
// assertion macros for the stereo plucked-string voice
// used by the rtl files that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef STEREO_PLUCKED_STRING_SYNTH_DEFINES_SVH
`define STEREO_PLUCKED_STRING_SYNTH_DEFINES_SVH

// check that is off while reset is held
`define SPSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also runs during reset
`define SPSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/spss_pkg.sv =====
// shared constants, types and saturation helpers of the stereo plucked-string voice
// no dependencies; imported by spss_hist and stereo_plucked_string_synth
`default_nettype none

package spss_pkg;

  // history line depth, a power of two
  localparam int unsigned HIST_DEPTH    = 1024;
  localparam int unsigned HIST_AW       = $clog2(HIST_DEPTH);
  localparam int unsigned BURST_SAMPLES = 2048;
  localparam int unsigned BURST_W       = 12;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 21;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef logic [HIST_AW-1:0] hist_addr_t;
  typedef logic signed [15:0] sample_t;
  typedef logic signed [19:0] loop_val_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_L,
    CFG_DELAY_R,
    CFG_COEF_L,
    CFG_COEF_R,
    CFG_FB_L,
    CFG_FB_R,
    CFG_GAIN_L,
    CFG_GAIN_R
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL_X,
    ST_MUL_H,
    ST_SUM_W,
    ST_MUL_A,
    ST_SUM_V,
    ST_MUL_G,
    ST_OUT
  } seq_state_e;

  // clamp a wide signed value to 20 bits
  function automatic loop_val_t sat20_f(input logic signed [39:0] v);
    loop_val_t r;
    if (v > 40'sd524287) begin
      r = 20'sd524287;
    end else if (v < -40'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  // clamp a wide signed value to 16 bits
  function automatic sample_t sat16_f(input logic signed [39:0] v);
    sample_t r;
    if (v > 40'sd32767) begin
      r = 16'sd32767;
    end else if (v < -40'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stereo_plucked_string_synth.sv =====
// Stereo Karplus-Strong string voice with allpass tuning. After reset the block
// zeroes both history lines and accepts no input word meanwhile; configuration
// writes are taken at any time. Each accepted word passes one history read, six
// steps per channel around a single shared 21x18 multiplier (four products per
// channel), and an output step that loads the output register and stalls while
// the previous result is unread; only then is the next word accepted. The result
// word waits in that register; the block is ready for the next input while it waits.
// Depends on spss_pkg, spss_hist and stereo_plucked_string_synth_defines.svh.
`default_nettype none

module stereo_plucked_string_synth (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [spss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [spss_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [15:0]                        s_axis_tdata_i,  // [15:0] noise_sample
  input  logic [0:0]                         s_axis_tuser_i,  // [0] pluck
  // output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [31:0]                        m_axis_tdata_o   // [15:0] left, [31:16] right
);
  import spss_pkg::*;

  `include "stereo_plucked_string_synth_defines.svh"

  localparam hist_addr_t HIST_LAST = hist_addr_t'(HIST_DEPTH - 1);

  // configuration registers, index 0 is left, 1 is right
  logic [9:0]         delay_q [2];
  logic signed [15:0] coef_q  [2];
  logic [16:0]        fb_q    [2];
  logic [15:0]        gain_q  [2];

  // sequencer and loop state
  seq_state_e         state_q, state_d;
  logic               ch_q, ch_d;
  hist_addr_t         clr_q;
  logic [BURST_W-1:0] burst_q;
  hist_addr_t         pos_q [2];
  loop_val_t          pv_q  [2];
  loop_val_t          pw_q  [2];
  logic               m_valid_q;

  // datapath registers
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] acc_q;
  loop_val_t                w_q;
  loop_val_t                v_q;
  sample_t                  x_q;
  sample_t                  out_l_q;
  logic [31:0]              tdata_q;

  logic in_acc;
  logic out_free;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q[0] <= 10'd100;
      delay_q[1] <= 10'd100;
      coef_q[0]  <= '0;
      coef_q[1]  <= '0;
      fb_q[0]    <= '0;
      fb_q[1]    <= '0;
      gain_q[0]  <= 16'd4096;
      gain_q[1]  <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY_L: delay_q[0] <= cfg_wdata_i[9:0];
        CFG_DELAY_R: delay_q[1] <= cfg_wdata_i[9:0];
        CFG_COEF_L:  coef_q[0]  <= cfg_wdata_i[15:0];
        CFG_COEF_R:  coef_q[1]  <= cfg_wdata_i[15:0];
        CFG_FB_L:    fb_q[0]    <= cfg_wdata_i;
        CFG_FB_R:    fb_q[1]    <= cfg_wdata_i;
        CFG_GAIN_L:  gain_q[0]  <= cfg_wdata_i[15:0];
        CFG_GAIN_R:  gain_q[1]  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // values of the channel in work
  hist_addr_t         pos_cur;
  logic [9:0]         delay_cur;
  logic signed [15:0] coef_cur;
  logic [16:0]        fb_cur;
  logic [15:0]        gain_cur;
  loop_val_t          pv_cur;
  loop_val_t          pw_cur;
  sample_t            h_cur;
  sample_t            rdata_l, rdata_r;
  logic [16:0]        p_sat;
  logic [16:0]        one_minus_p;

  assign pos_cur     = pos_q[ch_q];
  assign delay_cur   = delay_q[ch_q];
  assign coef_cur    = coef_q[ch_q];
  assign fb_cur      = fb_q[ch_q];
  assign gain_cur    = gain_q[ch_q];
  assign pv_cur      = pv_q[ch_q];
  assign pw_cur      = pw_q[ch_q];
  assign h_cur       = ch_q ? rdata_r : rdata_l;
  // feedback above one is clamped to one
  assign p_sat       = (fb_cur > 17'd65536) ? 17'd65536 : fb_cur;
  assign one_minus_p = 17'd65536 - p_sat;

  // y = round(v + prev_v, 1 bit)
  logic signed [20:0] ysum;
  loop_val_t          y_cur;

  assign ysum  = 21'(v_q) + 21'(pv_cur) + 21'sd1;
  assign y_cur = ysum[20:1];

  // next state
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == HIST_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_MUL_X;
        ch_d    = 1'b0;
      end
      ST_MUL_X: state_d = ST_MUL_H;
      ST_MUL_H: state_d = ST_SUM_W;
      ST_SUM_W: state_d = ST_MUL_A;
      ST_MUL_A: state_d = ST_SUM_V;
      ST_SUM_V: state_d = ST_MUL_G;
      ST_MUL_G: begin
        if (ch_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL_X;
          ch_d    = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: memory strobes and multiplier operands
  logic                      we_l, we_r, hist_re, mul_en;
  hist_addr_t                waddr;
  sample_t                   wdata;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    s_axis_tready_o = 1'b0;
    we_l            = 1'b0;
    we_r            = 1'b0;
    hist_re         = 1'b0;
    mul_en          = 1'b0;
    waddr           = clr_q;
    wdata           = '0;
    mul_a           = '0;
    mul_b           = '0;
    unique case (state_q)
      ST_CLEAR: begin
        we_l = 1'b1;
        we_r = 1'b1;
      end
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_READ: hist_re = 1'b1;
      ST_MUL_X: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(x_q);
        mul_b  = $signed({1'b0, one_minus_p});
      end
      ST_MUL_H: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(h_cur);
        mul_b  = $signed({1'b0, p_sat});
      end
      ST_MUL_A: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(w_q) - MUL_A_W'(pv_cur);
        mul_b  = MUL_B_W'(coef_cur);
      end
      ST_MUL_G: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(y_cur);
        mul_b  = $signed({2'b00, gain_cur});
        we_l   = !ch_q;
        we_r   = ch_q;
        waddr  = pos_cur + hist_addr_t'(delay_cur);
        wdata  = sat16_f(40'(y_cur));
      end
      default: ;
    endcase
  end

  // shared multiplier
  logic signed [PROD_W-1:0] mul_p;

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // rounding and saturation after each product
  logic signed [39:0] wsum, vrnd, ornd;
  loop_val_t          w_new, v_new;
  sample_t            out_cur;

  assign wsum    = 40'(acc_q) + 40'(prod_q) + 40'sd32768;
  assign w_new   = sat20_f(wsum >>> 16);
  assign vrnd    = (40'(prod_q) + 40'sd8192) >>> 14;
  assign v_new   = sat20_f(vrnd + 40'(pw_cur));
  assign ornd    = (40'(prod_q) + 40'sd2048) >>> 12;
  assign out_cur = sat16_f(ornd);

  // burst counter reload and excitation pick
  logic [BURST_W-1:0] burst_ld;
  logic               burst_act;

  assign burst_ld  = s_axis_tuser_i[0] ? BURST_W'(BURST_SAMPLES) : burst_q;
  assign burst_act = (burst_ld != '0);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ch_q      <= 1'b0;
      clr_q     <= '0;
      burst_q   <= '0;
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pv_q[0]   <= '0;
      pv_q[1]   <= '0;
      pw_q[0]   <= '0;
      pw_q[1]   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + hist_addr_t'(1);
      end
      if (in_acc) begin
        burst_q <= burst_act ? burst_ld - BURST_W'(1) : burst_ld;
      end
      // commit the channel's loop state with its history write
      if (state_q == ST_MUL_G) begin
        pv_q[ch_q]  <= v_q;
        pw_q[ch_q]  <= w_q;
        pos_q[ch_q] <= pos_cur + hist_addr_t'(1);
      end
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= burst_act ? sample_t'(s_axis_tdata_i) : '0;
    end
    if (mul_en) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_MUL_H) begin
      acc_q <= prod_q;
    end
    if (state_q == ST_SUM_W) begin
      w_q <= w_new;
    end
    if (state_q == ST_SUM_V) begin
      v_q <= v_new;
    end
    // left result is finished while the right channel starts
    if (state_q == ST_MUL_X && ch_q) begin
      out_l_q <= out_cur;
    end
    if (state_q == ST_OUT && out_free) begin
      tdata_q <= {out_cur, out_l_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = tdata_q;

  // history lines
  spss_hist u_hist_l (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (hist_re),
    .raddr_i (pos_q[0]),
    .rdata_o (rdata_l)
  );

  spss_hist u_hist_r (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (hist_re),
    .raddr_i (pos_q[1]),
    .rdata_o (rdata_r)
  );

  // checks
  `SPSS_ASSERT(a_accept_starts_read, in_acc |=> state_q == ST_READ, "accepted word did not start a read")
  `SPSS_ASSERT(a_valid_from_out, $rose(m_valid_q) |-> $past(state_q == ST_OUT), "result raised outside output step")
  `SPSS_ASSERT(a_hist_write_phase, (we_l || we_r) |-> (state_q == ST_CLEAR || state_q == ST_MUL_G), "history written outside clear or commit")
  `SPSS_ASSERT(a_single_chan_write, (state_q == ST_MUL_G) |-> $onehot({we_l, we_r}), "commit must write exactly one history line")

endmodule

`default_nettype wire

// ===== hw/rtl/spss_hist.sv =====
// circular history line of one string: one write port, one registered read port
// depends on spss_pkg for depth and sample types
`default_nettype none

module spss_hist (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  spss_pkg::hist_addr_t waddr_i,
  input  spss_pkg::sample_t    wdata_i,
  input  logic                 re_i,
  input  spss_pkg::hist_addr_t raddr_i,
  output spss_pkg::sample_t    rdata_o
);
  import spss_pkg::*;

  sample_t mem_q [HIST_DEPTH];
  sample_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
